[rtl/core/multi_token_response_waiter_defines.svh]
// Assertion macros shared by the multi-token response waiter RTL.
`ifndef MULTI_TOKEN_RESPONSE_WAITER_DEFINES_SVH
`define MULTI_TOKEN_RESPONSE_WAITER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define MTRW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MTRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MTRW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define MTRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/core/mtrw_pkg.sv]
// Shared constants and types of the multi-token response waiter.
`timescale 1ns / 1ps
`default_nettype none

package mtrw_pkg;

    // Fixed register map and widths
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int PATTERN_REGS = 4;
    localparam int PROG_W       = 4;
    localparam int TIMEOUT_W    = 16;

    // Parameter defaults
    localparam int MAX_TOKENS_DEF  = 4;
    localparam int TOKEN_CHARS_DEF = 8;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_A   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOKEN_COUNT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMING     = 3'd6;

    // Register reset values
    localparam logic [2:0]           TOKEN_COUNT_RESET = 3'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 16'd1000;

    // Item function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Framing modes
    localparam logic [1:0] FRAME_NONE = 2'd0;
    localparam logic [1:0] FRAME_DC1  = 2'd1;
    localparam logic [1:0] FRAME_DC2  = 2'd2;

    // Framing characters
    localparam logic [7:0] DC1_START = 8'h11;
    localparam logic [7:0] DC1_STOP  = 8'h13;
    localparam logic [7:0] DC2_START = 8'h12;
    localparam logic [7:0] DC2_STOP  = 8'h14;

    // Outcome codes
    localparam logic OUTCOME_MATCH   = 1'b0;
    localparam logic OUTCOME_TIMEOUT = 1'b1;

    // One item leaving the input register
    typedef struct packed {
        logic       fire;
        logic [1:0] func;
        logic [7:0] rx_byte;
    } item_t;

    // Command from the wait controller to every token lane
    typedef struct packed {
        logic       clear;
        logic       step;
        logic [7:0] rx_byte;
    } lane_cmd_t;

    // Result of one item
    typedef struct packed {
        logic       valid;
        logic       outcome;
        logic [1:0] index;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/multi_token_response_waiter.sv]
// Top level: configuration registers, input register, token lanes, result register.
`timescale 1ns / 1ps
`default_nettype none

// Multi-token response waiter. Each transfer on the input channel is a start,
// a received byte or a one-millisecond tick; a wait ends with one result
// transfer carrying either the index of the lowest-numbered token that
// completed or a timeout. Items pass an input register, the compare and
// update logic and a result register, and one item is taken every cycle
// while the output side keeps up. While a result waits on the output, one
// further item is still taken into the input register. Configuration writes
// take effect at once and should be made while no item is in flight.
module multi_token_response_waiter
    import mtrw_pkg::*;
#(
    parameter int MAX_TOKENS  = MAX_TOKENS_DEF,
    parameter int TOKEN_CHARS = TOKEN_CHARS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             func,
    input  wire logic [7:0]             rx_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        outcome,
    output logic [1:0]                  match_index,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LANES = (MAX_TOKENS < PATTERN_REGS) ? MAX_TOKENS : PATTERN_REGS;

    logic [CFG_DATA_W-1:0] pattern_reg [LANES];
    logic [2:0]            token_count_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [1:0]            framing_reg;

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [1:0] func_reg;
    logic [7:0] byte_reg;
    logic       out_vld_reg;
    logic       out_vld_next;
    logic       outcome_reg;
    logic [1:0] index_reg;

    logic             proc_fire;
    item_t            item;
    lane_cmd_t        cmd;
    logic [LANES-1:0] lane_en;
    logic [LANES-1:0] lane_hit;
    result_t          res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pattern_reg[i] <= '0;
            end
            token_count_reg <= TOKEN_COUNT_RESET;
            timeout_reg     <= TIMEOUT_RESET;
            framing_reg     <= FRAME_NONE;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (cfg_index == REG_PATTERN_A + CFG_INDEX_W'(i))
                begin
                    pattern_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == REG_TOKEN_COUNT)
            begin
                token_count_reg <= cfg_data[2:0];
            end
            if (cfg_index == REG_TIMEOUT)
            begin
                timeout_reg <= cfg_data[TIMEOUT_W-1:0];
            end
            if (cfg_index == REG_FRAMING)
            begin
                framing_reg <= cfg_data[1:0];
            end
        end
    end

    // Input register advances when the result register can take a result
    assign proc_fire   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready    = !in_vld_reg || proc_fire;
    assign in_vld_next = (in_valid && in_ready) || (in_vld_reg && !proc_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            byte_reg <= rx_byte;
        end
    end

    always_comb
    begin
        item.fire    = proc_fire;
        item.func    = func_reg;
        item.rx_byte = byte_reg;
    end

    // Token lanes
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        mtrw_token_lane #(
            .TOKEN_CHARS (TOKEN_CHARS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .pattern (pattern_reg[g][8*TOKEN_CHARS-1:0]),
            .cmd     (cmd),
            .enable  (lane_en[g]),
            .hit     (lane_hit[g])
        );
    end

    // Wait control
    mtrw_wait_ctrl #(
        .LANES (LANES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .token_count  (token_count_reg),
        .timeout_ms   (timeout_reg),
        .framing_mode (framing_reg),
        .lane_hit     (lane_hit),
        .cmd          (cmd),
        .lane_en      (lane_en),
        .res          (res)
    );

    // Result register
    always_comb
    begin
        out_vld_next = out_vld_reg && !out_ready;
        if (proc_fire && res.valid)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && res.valid)
        begin
            outcome_reg <= res.outcome;
            index_reg   <= res.index;
        end
    end

    assign out_valid   = out_vld_reg;
    assign outcome     = outcome_reg;
    assign match_index = index_reg;

endmodule

`default_nettype wire

[rtl/core/mtrw_token_lane.sv]
// One token lane: token length, next-character compare and match progress.
`timescale 1ns / 1ps
`default_nettype none

module mtrw_token_lane
    import mtrw_pkg::*;
#(
    parameter int TOKEN_CHARS = TOKEN_CHARS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [8*TOKEN_CHARS-1:0] pattern,
    input  wire lane_cmd_t                cmd,
    input  wire logic                     enable,
    output logic                          hit
);

    logic [PROG_W-1:0] prog_reg;
    logic [PROG_W-1:0] prog_next;
    logic [PROG_W-1:0] len;
    logic [PROG_W-1:0] prog_step;
    logic [7:0]        cur_char;

    // Token length: first zero character ends the token
    always_comb
    begin
        len = PROG_W'(TOKEN_CHARS);
        for (int i = TOKEN_CHARS - 1; i >= 0; i--)
        begin
            if (pattern[8*i +: 8] == 8'h00)
            begin
                len = PROG_W'(i);
            end
        end
    end

    // Character expected next
    always_comb
    begin
        cur_char = 8'h00;
        for (int i = 0; i < TOKEN_CHARS; i++)
        begin
            if (prog_reg == PROG_W'(i))
            begin
                cur_char = pattern[8*i +: 8];
            end
        end
    end

    // Advance on the expected character, otherwise fall back to zero
    always_comb
    begin
        if (prog_reg < len && cmd.rx_byte == cur_char)
        begin
            prog_step = prog_reg + PROG_W'(1);
        end
        else
        begin
            prog_step = '0;
        end
    end

    assign hit = cmd.step && enable && (prog_step == len);

    // Progress update
    always_comb
    begin
        prog_next = prog_reg;
        if (cmd.clear)
        begin
            prog_next = '0;
        end
        else if (cmd.step && enable)
        begin
            prog_next = prog_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg <= '0;
        end
        else
        begin
            prog_reg <= prog_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mtrw_wait_ctrl.sv]
// Wait controller: wait state, timeout counter, framing flags and result pick.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_token_response_waiter_defines.svh"

module mtrw_wait_ctrl
    import mtrw_pkg::*;
#(
    parameter int LANES = MAX_TOKENS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire item_t                item,
    input  wire logic [2:0]           token_count,
    input  wire logic [TIMEOUT_W-1:0] timeout_ms,
    input  wire logic [1:0]           framing_mode,
    input  wire logic [LANES-1:0]     lane_hit,
    output lane_cmd_t                 cmd,
    output logic [LANES-1:0]          lane_en,
    output result_t                   res
);

    logic                 waiting_reg;
    logic                 waiting_next;
    logic [TIMEOUT_W-1:0] elapsed_reg;
    logic [TIMEOUT_W-1:0] elapsed_next;
    logic                 frame_open_reg;
    logic                 frame_open_next;
    logic                 frame_closed_reg;
    logic                 frame_closed_next;

    logic [3:0]           tokens_used;
    logic                 framed;
    logic [7:0]           start_char;
    logic [7:0]           stop_char;
    logic                 closed_now;
    logic                 in_frame;
    logic                 any_hit;
    logic [1:0]           hit_index;
    logic [TIMEOUT_W-1:0] elapsed_inc;

    // Tokens in use, clamped to one..lanes
    always_comb
    begin
        tokens_used = {1'b0, token_count};
        if (tokens_used == 4'd0)
        begin
            tokens_used = 4'd1;
        end
        if (tokens_used > 4'(PATTERN_REGS))
        begin
            tokens_used = 4'(PATTERN_REGS);
        end
        if (tokens_used > 4'(LANES))
        begin
            tokens_used = 4'(LANES);
        end
        for (int i = 0; i < LANES; i++)
        begin
            lane_en[i] = (4'(i) < tokens_used);
        end
    end

    // Framing characters of the selected mode
    always_comb
    begin
        case (framing_mode)
            FRAME_DC1:
            begin
                framed     = 1'b1;
                start_char = DC1_START;
                stop_char  = DC1_STOP;
            end
            FRAME_DC2:
            begin
                framed     = 1'b1;
                start_char = DC2_START;
                stop_char  = DC2_STOP;
            end
            default:
            begin
                framed     = 1'b0;
                start_char = DC1_START;
                stop_char  = DC1_STOP;
            end
        endcase
    end

    // Stop character closes the frame before this byte is judged
    assign closed_now = frame_closed_reg || (item.rx_byte == stop_char);
    assign in_frame   = !framed || (frame_open_reg && !closed_now);

    // Lane command
    always_comb
    begin
        cmd.clear   = item.fire && item.func == FUNC_START;
        cmd.step    = item.fire && item.func == FUNC_BYTE && waiting_reg && in_frame;
        cmd.rx_byte = item.rx_byte;
    end

    // Lowest-numbered completed token wins
    always_comb
    begin
        any_hit   = |lane_hit;
        hit_index = 2'd0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (lane_hit[i])
            begin
                hit_index = 2'(i);
            end
        end
    end

    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + TIMEOUT_W'(1) : elapsed_reg;

    // Next state and result
    always_comb
    begin
        waiting_next      = waiting_reg;
        elapsed_next      = elapsed_reg;
        frame_open_next   = frame_open_reg;
        frame_closed_next = frame_closed_reg;
        res.valid         = 1'b0;
        res.outcome       = OUTCOME_MATCH;
        res.index         = 2'd0;
        if (item.fire)
        begin
            case (item.func)
                FUNC_START:
                begin
                    elapsed_next      = '0;
                    frame_open_next   = 1'b0;
                    frame_closed_next = 1'b0;
                    waiting_next      = 1'b1;
                    if (timeout_ms == '0)
                    begin
                        waiting_next = 1'b0;
                        res.valid    = 1'b1;
                        res.outcome  = OUTCOME_TIMEOUT;
                    end
                end
                FUNC_TICK:
                begin
                    if (waiting_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= timeout_ms)
                        begin
                            waiting_next = 1'b0;
                            res.valid    = 1'b1;
                            res.outcome  = OUTCOME_TIMEOUT;
                        end
                    end
                end
                FUNC_BYTE:
                begin
                    if (waiting_reg)
                    begin
                        if (framed)
                        begin
                            frame_closed_next = closed_now;
                            if (!any_hit && item.rx_byte == start_char)
                            begin
                                frame_open_next = 1'b1;
                            end
                        end
                        if (any_hit)
                        begin
                            waiting_next = 1'b0;
                            res.valid    = 1'b1;
                            res.outcome  = OUTCOME_MATCH;
                            res.index    = hit_index;
                        end
                    end
                end
                default:
                begin
                    waiting_next = waiting_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg      <= 1'b0;
            elapsed_reg      <= '0;
            frame_open_reg   <= 1'b0;
            frame_closed_reg <= 1'b0;
        end
        else
        begin
            waiting_reg      <= waiting_next;
            elapsed_reg      <= elapsed_next;
            frame_open_reg   <= frame_open_next;
            frame_closed_reg <= frame_closed_next;
        end
    end

    // Checks
    `MTRW_ASSERT_NEXT(a_result_ends_wait, clk, rst_n, res.valid, !waiting_reg, "wait still open after a result")
    `MTRW_ASSERT_SAME(a_idle_silent, clk, rst_n, !waiting_reg && item.func != FUNC_START, !res.valid, "result while idle")
    `MTRW_ASSERT_SAME(a_match_from_byte, clk, rst_n, res.valid && res.outcome == OUTCOME_MATCH, item.func == FUNC_BYTE && cmd.step, "match without a matched byte")
    `MTRW_ASSERT_NEXT(a_start_clears, clk, rst_n, item.fire && item.func == FUNC_START, elapsed_reg == '0 && !frame_open_reg && !frame_closed_reg, "start did not clear the wait")

endmodule

`default_nettype wire

[tb/multi_token_response_waiter_tb.sv]
// Testbench for the multi-token response waiter: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module multi_token_response_waiter_tb;
    import mtrw_pkg::*;

    localparam logic [1:0] FUNC_IGNORED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_B = REG_PATTERN_A + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_C = REG_PATTERN_A + 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_D = REG_PATTERN_A + 3'd3;

    localparam logic [7:0]  CHAR_O      = 8'h4F;
    localparam logic [7:0]  CHAR_K      = 8'h4B;
    localparam logic [63:0] TOKEN_OK    = 64'h4B4F;
    localparam logic [63:0] TOKEN_O     = 64'h4F;
    localparam logic [63:0] TOKEN_WIDE  = 64'hFF80_7F01_FEC3_3C81;

    localparam int RANDOM_ITEMS  = 1500;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 8;

    typedef enum logic [2:0] {
        STEP_ITEM,
        STEP_WRITE,
        STEP_SYNC,
        STEP_HOLD,
        STEP_PACE
    } step_kind_t;

    typedef struct {
        step_kind_t                 kind;
        logic [1:0]                 fn;
        logic [7:0]                 ch;
        logic [CFG_INDEX_W-1:0]     reg_index;
        logic [CFG_DATA_W-1:0]      value;
    } step_t;

    typedef struct packed {
        logic       outcome;
        logic [1:0] index;
    } verdict_t;

    // Block ports
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             func = FUNC_START;
    logic [7:0]             rx_byte = 8'h00;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   outcome;
    logic [1:0]             match_index;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Transfers seen at the last rising edge
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;

    // Traffic shaping state; brisk and the hold settings are shared between sender and receiver
    logic brisk = 1'b0;
    int   hold_len = 0;
    int   hold_seq = 0;
    int   hold_taken = 0;
    int   hold_left = 0;
    int   stall_left = 0;
    int   gap_left = 0;
    int   settle_left = 0;

    step_t    pending_steps[$];
    verdict_t verdicts_due[$];
    int       mismatches = 0;
    int       stimulus_items = 0;

    // Generator's view of the programmed tokens and framing
    logic [63:0] gen_words[PATTERN_REGS] = '{default: '0};
    logic [1:0]  gen_framing = FRAME_NONE;

    // Predicted registers and wait state
    logic [63:0]          waiter_words[PATTERN_REGS] = '{default: '0};
    logic [2:0]           waiter_count = TOKEN_COUNT_RESET;
    logic [TIMEOUT_W-1:0] waiter_timeout = TIMEOUT_RESET;
    logic [1:0]           waiter_framing = FRAME_NONE;
    logic [PROG_W-1:0]    token_progress[PATTERN_REGS] = '{default: '0};
    logic [TIMEOUT_W-1:0] elapsed_ms = '0;
    logic                 wait_active = 1'b0;
    logic                 frame_open = 1'b0;
    logic                 frame_closed = 1'b0;

    multi_token_response_waiter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .outcome     (outcome),
        .match_index (match_index),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Length runs up to the first zero character
    function automatic int token_length(input int t);
        int i;
        for (i = 0; i < TOKEN_CHARS_DEF; i++)
            if (waiter_words[t][8*i +: 8] == 8'h00)
                return i;
        return TOKEN_CHARS_DEF;
    endfunction

    // Step every token in use; the first one to complete stops the scan
    function automatic int match_tokens(input logic [7:0] ch);
        int live;
        int t;
        int len;
        int p;
        int hit;
        live = (waiter_count == 3'd0) ? 1 :
               (int'(waiter_count) > PATTERN_REGS) ? PATTERN_REGS : int'(waiter_count);
        hit = -1;
        for (t = 0; t < live && hit < 0; t++)
        begin
            len = token_length(t);
            p = int'(token_progress[t]);
            if (p < len && ch == waiter_words[t][8*p +: 8])
                p++;
            else
                p = 0;
            token_progress[t] = p[PROG_W-1:0];
            if (p == len)
                hit = t;
        end
        return hit;
    endfunction

    function automatic void store_waiter_reg(input logic [CFG_INDEX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] data);
        if (idx < PATTERN_REGS)
            waiter_words[idx[1:0]] = data;
        else if (idx == REG_TOKEN_COUNT)
            waiter_count = data[2:0];
        else if (idx == REG_TIMEOUT)
            waiter_timeout = data[TIMEOUT_W-1:0];
        else if (idx == REG_FRAMING)
            waiter_framing = data[1:0];
    endfunction

    function automatic void advance_waiter(input logic [1:0] fn, input logic [7:0] ch,
                                           output bit produced, output verdict_t v);
        int         t;
        int         hit;
        logic [7:0] open_ch;
        logic [7:0] close_ch;
        produced = 1'b0;
        v = '0;
        case (fn)
            FUNC_START:
            begin
                for (t = 0; t < PATTERN_REGS; t++)
                    token_progress[t] = '0;
                elapsed_ms = '0;
                frame_open = 1'b0;
                frame_closed = 1'b0;
                wait_active = 1'b1;
                if (waiter_timeout == '0)
                begin
                    wait_active = 1'b0;
                    produced = 1'b1;
                    v.outcome = OUTCOME_TIMEOUT;
                end
            end
            FUNC_TICK:
            begin
                if (wait_active)
                begin
                    if (elapsed_ms != '1)
                        elapsed_ms++;
                    if (elapsed_ms >= waiter_timeout)
                    begin
                        wait_active = 1'b0;
                        produced = 1'b1;
                        v.outcome = OUTCOME_TIMEOUT;
                    end
                end
            end
            FUNC_BYTE:
            begin
                if (wait_active)
                begin
                    hit = -1;
                    if (waiter_framing == FRAME_DC1 || waiter_framing == FRAME_DC2)
                    begin
                        open_ch = (waiter_framing == FRAME_DC1) ? DC1_START : DC2_START;
                        close_ch = (waiter_framing == FRAME_DC1) ? DC1_STOP : DC2_STOP;
                        if (ch == close_ch)
                            frame_closed = 1'b1;
                        // open/closed are judged before this byte can open the frame
                        if (frame_open && !frame_closed)
                            hit = match_tokens(ch);
                        if (hit < 0 && ch == open_ch)
                            frame_open = 1'b1;
                    end
                    else
                    begin
                        hit = match_tokens(ch);
                    end
                    if (hit >= 0)
                    begin
                        wait_active = 1'b0;
                        produced = 1'b1;
                        v.outcome = OUTCOME_MATCH;
                        v.index = hit[1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void log_mismatch(input string msg);
        if (mismatches < 10)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus queue helpers
    // ---------------------------------------------------------------

    task automatic add_step(input step_kind_t kind, input logic [1:0] fn,
                            input logic [7:0] ch, input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] value);
        step_t s;
        s.kind = kind;
        s.fn = fn;
        s.ch = ch;
        s.reg_index = idx;
        s.value = value;
        pending_steps.push_back(s);
    endtask

    task automatic add_item(input logic [1:0] fn, input logic [7:0] ch);
        add_step(STEP_ITEM, fn, ch, '0, '0);
        if (fn != FUNC_IGNORED)
            stimulus_items++;
    endtask

    task automatic add_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        add_step(STEP_WRITE, FUNC_START, 8'h00, idx, value);
        if (idx < PATTERN_REGS)
            gen_words[idx[1:0]] = value;
        else if (idx == REG_FRAMING)
            gen_framing = value[1:0];
    endtask

    task automatic add_sync();
        add_step(STEP_SYNC, FUNC_START, 8'h00, '0, '0);
    endtask

    // Ticks, ignored codes, random bytes and stray token characters
    task automatic add_noise();
        int pos;
        int t;
        pos = $urandom_range(0, 7);
        t = $urandom_range(0, PATTERN_REGS - 1);
        case ($urandom_range(0, 9))
            0, 1, 2: add_item(FUNC_TICK, 8'($urandom));
            3:       add_item(FUNC_IGNORED, 8'($urandom));
            4, 5, 6: add_item(FUNC_BYTE, 8'($urandom));
            default: add_item(FUNC_BYTE, gen_words[t][8*pos +: 8]);
        endcase
    endtask

    // ---------------------------------------------------------------
    // Sender: presents one step per free slot at the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : sender
        step_t                  head;
        logic                   valid_next;
        logic [1:0]             func_next;
        logic [7:0]             byte_next;
        logic                   we_next;
        logic [CFG_INDEX_W-1:0] index_next;
        logic [CFG_DATA_W-1:0]  data_next;
        valid_next = in_valid;
        func_next = func;
        byte_next = rx_byte;
        we_next = 1'b0;
        index_next = cfg_index;
        data_next = cfg_data;
        if (!rst_n)
        begin
            valid_next = 1'b0;
        end
        else if (!(in_valid && !in_fire))
        begin
            valid_next = 1'b0;
            if (settle_left > 0)
                settle_left--;
            else if (gap_left > 0)
                gap_left--;
            else if (pending_steps.size() != 0)
            begin
                head = pending_steps[0];
                case (head.kind)
                    STEP_ITEM:
                    begin
                        void'(pending_steps.pop_front());
                        valid_next = 1'b1;
                        func_next = head.fn;
                        byte_next = head.ch;
                        gap_left = brisk ? 0 : $urandom_range(0, 3);
                    end
                    STEP_WRITE:
                    begin
                        void'(pending_steps.pop_front());
                        we_next = 1'b1;
                        index_next = head.reg_index;
                        data_next = head.value;
                    end
                    STEP_SYNC:
                    begin
                        // hold back until every result is in, then let the pipe drain
                        if (verdicts_due.size() == 0)
                        begin
                            void'(pending_steps.pop_front());
                            settle_left = SETTLE_CYCLES;
                        end
                    end
                    STEP_HOLD:
                    begin
                        void'(pending_steps.pop_front());
                        hold_len <= int'(head.value[15:0]);
                        hold_seq <= hold_seq + 1;
                    end
                    STEP_PACE:
                    begin
                        void'(pending_steps.pop_front());
                        brisk <= head.value[0];
                    end
                    default:
                    begin
                        void'(pending_steps.pop_front());
                    end
                endcase
            end
        end
        in_valid <= valid_next;
        func <= func_next;
        rx_byte <= byte_next;
        cfg_we <= we_next;
        cfg_index <= index_next;
        cfg_data <= data_next;
    end

    // ---------------------------------------------------------------
    // Receiver: random stall after each transfer, plus long holds
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : receiver
        logic ready_next;
        ready_next = 1'b0;
        if (rst_n)
        begin
            if (hold_seq != hold_taken)
            begin
                hold_taken = hold_seq;
                hold_left = hold_len;
            end
            if (out_fire)
                stall_left = brisk ? 0 : $urandom_range(0, 3);
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else
                ready_next = 1'b1;
        end
        out_ready <= ready_next;
    end

    // ---------------------------------------------------------------
    // Monitor: mirror config writes, predict on input transfers, check results
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        verdict_t want;
        verdict_t fresh;
        bit       produced;
        in_fire <= in_valid && in_ready;
        out_fire <= out_valid && out_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    log_mismatch($sformatf("result outcome %0d index %0d with none expected",
                                           outcome, match_index));
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (outcome !== want.outcome || match_index !== want.index)
                        log_mismatch($sformatf("outcome %0d index %0d, expected %0d index %0d",
                                               outcome, match_index,
                                               want.outcome, want.index));
                end
            end
            if (cfg_we)
                store_waiter_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                advance_waiter(func, rx_byte, produced, fresh);
                if (produced)
                    verdicts_due.push_back(fresh);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int          k;
        int          i;
        int          len;
        int          pick;
        int          t;
        int          bad;
        int          wait_cycles;
        bit          shared;
        bit          framed;
        logic [7:0]  ch;
        logic [7:0]  open_ch;
        logic [7:0]  close_ch;
        logic [63:0] word;

        // Idle block ignores bytes, ticks and unused codes
        add_item(FUNC_BYTE, 8'h00);
        add_item(FUNC_TICK, 8'hFF);
        add_item(FUNC_IGNORED, 8'hFF);
        // Reset patterns are empty, so the first byte completes token 0
        add_item(FUNC_START, 8'h00);
        add_item(FUNC_BYTE, 8'hFF);

        add_sync();
        add_write(REG_PATTERN_A, TOKEN_OK);
        add_write(REG_PATTERN_B, TOKEN_WIDE);
        add_write(REG_PATTERN_C, {56'h0, DC2_STOP});
        add_write(REG_PATTERN_D, TOKEN_OK);
        add_write(REG_TOKEN_COUNT, 64'd7);
        add_write(REG_TIMEOUT, 64'd2);
        add_write(REG_FRAMING, {62'h0, FRAME_DC1});
        // Byte ahead of the frame is skipped; tokens 0 and 3 tie, lowest wins
        add_item(FUNC_START, 8'h00);
        add_item(FUNC_BYTE, CHAR_O);
        add_item(FUNC_BYTE, DC1_START);
        add_item(FUNC_BYTE, CHAR_O);
        add_item(FUNC_BYTE, CHAR_K);
        // Broken token: the breaking byte is not retried, then ticks run out
        add_item(FUNC_START, 8'hFF);
        add_item(FUNC_BYTE, DC1_START);
        add_item(FUNC_BYTE, CHAR_O);
        add_item(FUNC_BYTE, CHAR_O);
        add_item(FUNC_BYTE, CHAR_K);
        add_item(FUNC_TICK, 8'h00);
        add_item(FUNC_TICK, 8'h00);
        // Zero timeout ends the wait on the start itself
        add_sync();
        add_write(REG_TIMEOUT, 64'd0);
        add_item(FUNC_START, 8'h00);
        // Token shortened under an open wait: stale progress is cleared first
        add_sync();
        add_write(REG_TIMEOUT, 64'hFFFF);
        add_item(FUNC_START, 8'h00);
        add_item(FUNC_BYTE, DC1_START);
        add_item(FUNC_BYTE, CHAR_O);
        add_sync();
        add_write(REG_PATTERN_A, TOKEN_O);
        add_item(FUNC_BYTE, CHAR_O);
        add_item(FUNC_BYTE, CHAR_O);

        // Back-pressure: results pile up behind a held receiver
        add_sync();
        add_write(REG_FRAMING, {62'h0, FRAME_NONE});
        add_write(REG_TIMEOUT, 64'd0);
        add_step(STEP_PACE, FUNC_START, 8'h00, '0, 64'd1);
        add_step(STEP_HOLD, FUNC_START, 8'h00, '0, 64'(HOLD_CYCLES));
        repeat (20)
            add_item(FUNC_START, 8'($urandom));
        add_sync();
        add_step(STEP_PACE, FUNC_START, 8'h00, '0, 64'd0);

        // Random phases: new settings, then well-formed exchanges with noise
        stimulus_items = 0;
        while (stimulus_items < RANDOM_ITEMS)
        begin
            add_sync();
            add_step(STEP_PACE, FUNC_START, 8'h00, '0, 64'($urandom_range(0, 5) == 0));
            for (k = 0; k < PATTERN_REGS; k++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, TOKEN_CHARS_DEF);
                    shared = (k > 0) && ($urandom_range(0, 2) == 0);
                    pick = $urandom_range(0, 7);
                    for (i = 0; i < 8; i++)
                    begin
                        if (i > len)
                            ch = 8'($urandom);
                        else if (i == len)
                            ch = 8'h00;
                        else if (shared && i != pick && gen_words[k-1][8*i +: 8] != 8'h00)
                            ch = gen_words[k-1][8*i +: 8];
                        else
                            ch = 8'($urandom_range(1, 255));
                        word[8*i +: 8] = ch;
                    end
                    if ($urandom_range(0, 19) == 0)
                        word = '1;
                    add_write(REG_PATTERN_A + CFG_INDEX_W'(k), word);
                end
            end
            if ($urandom_range(0, 3) != 0)
                add_write(REG_TOKEN_COUNT, 64'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       add_write(REG_TIMEOUT, 64'd0);
                    1:       add_write(REG_TIMEOUT, 64'hFFFF);
                    default: add_write(REG_TIMEOUT, 64'($urandom_range(1, 24)));
                endcase
            end
            if ($urandom_range(0, 3) != 0)
                add_write(REG_FRAMING, 64'($urandom_range(0, 3)));

            framed = (gen_framing == FRAME_DC1) || (gen_framing == FRAME_DC2);
            open_ch = (gen_framing == FRAME_DC1) ? DC1_START : DC2_START;
            close_ch = (gen_framing == FRAME_DC1) ? DC1_STOP : DC2_STOP;

            repeat ($urandom_range(2, 5))
            begin
                if ($urandom_range(0, 9) != 0)
                    add_item(FUNC_START, 8'($urandom));
                if (framed)
                begin
                    if ($urandom_range(0, 3) == 0)
                        add_noise();
                    if ($urandom_range(0, 7) != 0)
                        add_item(FUNC_BYTE, open_ch);
                end
                repeat ($urandom_range(0, 2))
                    add_noise();
                // Send one token, sometimes with a corrupted character
                t = $urandom_range(0, PATTERN_REGS - 1);
                bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 8;
                for (i = 0; i < 8 && gen_words[t][8*i +: 8] != 8'h00; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        add_item(FUNC_TICK, 8'($urandom));
                    if (framed && $urandom_range(0, 24) == 0)
                        add_item(FUNC_BYTE, close_ch);
                    add_item(FUNC_BYTE, (i == bad) ? 8'($urandom) : gen_words[t][8*i +: 8]);
                end
                repeat ($urandom_range(0, 2))
                    add_noise();
            end
        end

        // Reset is held from the start and released at a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_steps.size() != 0 || in_valid)
            @(posedge clk);
        for (wait_cycles = 0; wait_cycles < 4000 && verdicts_due.size() != 0; wait_cycles++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (verdicts_due.size() != 0)
            log_mismatch($sformatf("%0d expected results never arrived", verdicts_due.size()));

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
